FILE: rtl/bptc_pkg.sv
`timescale 1ns / 1ps
package bptc_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int RawW     = 24;
  localparam int TempW    = 20;
  localparam int PresW    = 32;

  localparam logic [CfgIdxW-1:0] RegPresSens    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPresOffset  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSensTc      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOffsetTc    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRefTemp     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTempCoeff   = 3'd5;

  // 20.00 C in centidegrees
  localparam logic signed [TempW-1:0] TempBase   = 20'sd2000;
  // distance from 20.00 C down to -15.00 C
  localparam logic signed [18:0]      ColdOffset = 19'sd3500;

  localparam int Latency = 9;

endpackage

FILE: rtl/baro_pressure_temp_compensation_top.sv
`timescale 1ns / 1ps
// channel  | ports                                            | handshake
// ---------+--------------------------------------------------+----------------------------
// input    | raw_pressure, raw_temperature                    | start && !busy at clk edge
// result   | temperature_centi, pressure_centi_mbar           | done, one cycle per beat
// config   | cfg_index, cfg_data                              | cfg_we at clk edge
//
// Nine register stages; one beat accepted every cycle, result registered on the ports by the last.
// The stages include three multiplier stages (dT products, squares, split D1*SENS)
// and add and subtract stages, 25 to 65 bits wide, before, between and after them.
// rst is synchronous; busy is high only while rst is asserted; all stage valids clear.
// The result side has no back-pressure: done is a one-cycle strobe per beat.
module baro_pressure_temp_compensation_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [bptc_pkg::RawW-1:0]           raw_pressure,
  input  logic [bptc_pkg::RawW-1:0]           raw_temperature,
  input  logic                                cfg_we,
  input  logic [bptc_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [bptc_pkg::CfgDataW-1:0]       cfg_data,
  output logic                                done,
  output logic signed [bptc_pkg::TempW-1:0]   temperature_centi,
  output logic signed [bptc_pkg::PresW-1:0]   pressure_centi_mbar
);

  logic [bptc_pkg::CfgDataW-1:0] cal_c1, cal_c2, cal_c3, cal_c4, cal_c5, cal_c6;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_c1 <= '0;
      cal_c2 <= '0;
      cal_c3 <= '0;
      cal_c4 <= '0;
      cal_c5 <= '0;
      cal_c6 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bptc_pkg::RegPresSens:   cal_c1 <= cfg_data;
        bptc_pkg::RegPresOffset: cal_c2 <= cfg_data;
        bptc_pkg::RegSensTc:     cal_c3 <= cfg_data;
        bptc_pkg::RegOffsetTc:   cal_c4 <= cfg_data;
        bptc_pkg::RegRefTemp:    cal_c5 <= cfg_data;
        bptc_pkg::RegTempCoeff:  cal_c6 <= cfg_data;
        default: ;
      endcase
    end
  end

  logic acc;
  assign busy = rst;
  assign acc  = start && !busy;

  logic [8:1] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[7:1], acc};
      done <= vld[8];
    end
  end

  // stage 1: dT
  logic signed [24:0] dt_next, dt_s1;
  logic [23:0]        d1_s1;
  assign dt_next = 25'($signed({2'b00, raw_temperature}) - $signed({2'b00, cal_c5, 8'h00}));

  // stage 2: products against dT
  logic signed [41:0] pt6_next, pt4_next, pt3_next, pt6_s2, pt4_s2, pt3_s2;
  logic signed [49:0] pdd_next, pdd_s2;
  logic [23:0]        d1_s2;
  assign pt6_next = dt_s1 * $signed({1'b0, cal_c6});
  assign pt4_next = dt_s1 * $signed({1'b0, cal_c4});
  assign pt3_next = dt_s1 * $signed({1'b0, cal_c3});
  assign pdd_next = dt_s1 * dt_s1;

  // stage 3: first-order terms
  logic signed [18:0] x_next, y_next, x_s3, y_s3, t2_next, t2_s3;
  logic signed [19:0] temp1_next, temp1_s3;
  logic signed [39:0] off1_next, sens1_next, off1_s3, sens1_s3;
  logic               neg_s3, cold_s3;
  logic [23:0]        d1_s3;
  assign x_next     = pt6_s2[41:23];
  assign y_next     = x_next + bptc_pkg::ColdOffset;
  assign temp1_next = {x_next[18], x_next} + bptc_pkg::TempBase;
  assign t2_next    = pdd_s2[49:31];
  assign off1_next  = $signed({8'h00, cal_c2, 16'h0000})
                    + $signed({{5{pt4_s2[41]}}, pt4_s2[41:7]});
  assign sens1_next = $signed({9'h000, cal_c1, 15'h0000})
                    + $signed({{6{pt3_s2[41]}}, pt3_s2[41:8]});

  // stage 4: squares for the low-temperature terms
  logic signed [37:0] xx_next, yy_next, xx_s4, yy_s4;
  logic signed [18:0] t2_s4;
  logic signed [19:0] temp1_s4;
  logic signed [39:0] off1_s4, sens1_s4;
  logic               neg_s4, cold_s4;
  logic [23:0]        d1_s4;
  assign xx_next = x_s3 * x_s3;
  assign yy_next = y_s3 * y_s3;

  // stage 5: second-order corrections
  logic signed [39:0] xx40, yy40, five_xx, seven_yy, eleven_yy;
  logic signed [39:0] off2a_next, sens2a_next, off2b_next, sens2b_next;
  logic signed [39:0] off2a_s5, sens2a_s5, off2b_s5, sens2b_s5, off1_s5, sens1_s5;
  logic signed [19:0] temp_next, temp_s5;
  logic               neg_s5;
  logic [23:0]        d1_s5;
  assign xx40      = 40'(xx_s4);
  assign yy40      = 40'(yy_s4);
  assign five_xx   = (xx40 <<< 2) + xx40;
  assign seven_yy  = (yy40 <<< 3) - yy40;
  assign eleven_yy = (yy40 <<< 3) + (yy40 <<< 1) + yy40;
  assign off2a_next  = neg_s4  ? (five_xx >>> 1)   : '0;
  assign sens2a_next = neg_s4  ? (five_xx >>> 2)   : '0;
  assign off2b_next  = cold_s4 ? seven_yy          : '0;
  assign sens2b_next = cold_s4 ? (eleven_yy >>> 1) : '0;
  assign temp_next   = neg_s4 ? (temp1_s4 - $signed({1'b0, t2_s4})) : temp1_s4;

  // stage 6: final OFF and SENS
  logic signed [39:0] off_next, sens_next, off_s6, sens_s6;
  logic signed [19:0] temp_s6;
  logic [23:0]        d1_s6;
  assign off_next  = off1_s5 - off2a_s5 - off2b_s5;
  assign sens_next = sens1_s5 - sens2a_s5 - sens2b_s5;

  // stage 7: D1 * SENS as two partial products
  logic [43:0]        plo_next, plo_s7;
  logic signed [44:0] phi_next, phi_s7;
  logic signed [39:0] off_s7;
  logic signed [19:0] temp_s7;
  assign plo_next = d1_s6 * sens_s6[19:0];
  assign phi_next = $signed({1'b0, d1_s6}) * $signed(sens_s6[39:20]);

  // stage 8: recombine
  logic signed [64:0] prod_next, prod_s8;
  logic signed [39:0] off_s8;
  logic signed [19:0] temp_s8;
  assign prod_next = $signed({phi_s7, 20'h00000}) + $signed({21'h000000, plo_s7});

  // stage 9: pressure; 31-bit result always inside the 32-bit range, clamp never engages
  logic signed [45:0] pdiff;
  logic signed [30:0] pres;
  assign pdiff = $signed({{2{prod_s8[64]}}, prod_s8[64:21]}) - $signed({{6{off_s8[39]}}, off_s8});
  assign pres  = pdiff[45:15];

  always_ff @(posedge clk) begin
    dt_s1    <= dt_next;
    d1_s1    <= raw_pressure;

    pt6_s2   <= pt6_next;
    pt4_s2   <= pt4_next;
    pt3_s2   <= pt3_next;
    pdd_s2   <= pdd_next;
    d1_s2    <= d1_s1;

    x_s3     <= x_next;
    y_s3     <= y_next;
    t2_s3    <= t2_next;
    temp1_s3 <= temp1_next;
    off1_s3  <= off1_next;
    sens1_s3 <= sens1_next;
    neg_s3   <= x_next[18];
    cold_s3  <= y_next[18];
    d1_s3    <= d1_s2;

    xx_s4    <= xx_next;
    yy_s4    <= yy_next;
    t2_s4    <= t2_s3;
    temp1_s4 <= temp1_s3;
    off1_s4  <= off1_s3;
    sens1_s4 <= sens1_s3;
    neg_s4   <= neg_s3;
    cold_s4  <= cold_s3;
    d1_s4    <= d1_s3;

    off2a_s5  <= off2a_next;
    sens2a_s5 <= sens2a_next;
    off2b_s5  <= off2b_next;
    sens2b_s5 <= sens2b_next;
    off1_s5   <= off1_s4;
    sens1_s5  <= sens1_s4;
    temp_s5   <= temp_next;
    neg_s5    <= neg_s4;
    d1_s5     <= d1_s4;

    off_s6   <= off_next;
    sens_s6  <= sens_next;
    temp_s6  <= temp_s5;
    d1_s6    <= d1_s5;

    plo_s7   <= plo_next;
    phi_s7   <= phi_next;
    off_s7   <= off_s6;
    temp_s7  <= temp_s6;

    prod_s8  <= prod_next;
    off_s8   <= off_s7;
    temp_s8  <= temp_s7;

    temperature_centi   <= temp_s8;
    pressure_centi_mbar <= {pres[30], pres};
  end

  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    acc |-> ##(bptc_pkg::Latency) done)
    else $error("accepted beat did not produce a result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(acc, bptc_pkg::Latency))
    else $error("result without an accepted beat");

  a_cold_is_low: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> (!cold_s3 || neg_s3))
    else $error("below -15 C flag without below 20 C flag");

  a_temp_side: assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> ((temp_s5 < bptc_pkg::TempBase) == neg_s5))
    else $error("corrected temperature on wrong side of 20 C");

endmodule

FILE: tb/baro_pressure_temp_compensation_top_test.sv
`timescale 1ns / 1ps
module baro_pressure_temp_compensation_top_test;

  typedef logic [bptc_pkg::RegTempCoeff:0][bptc_pkg::CfgDataW-1:0] cal_set_t;

  typedef struct packed {
    logic signed [bptc_pkg::TempW-1:0] centi_deg;
    logic signed [bptc_pkg::PresW-1:0] centi_mbar;
  } reading_t;

  typedef struct packed {
    bit                          reload;
    cal_set_t                    cal;
    logic [bptc_pkg::RawW-1:0]   pres_raw;
    logic [bptc_pkg::RawW-1:0]   temp_raw;
    bit                          typed;
    reading_t                    want;
  } stim_row_t;

  localparam logic [bptc_pkg::CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [bptc_pkg::CfgIdxW-1:0] RegSpareHi = 3'd7;

  localparam logic [bptc_pkg::RawW-1:0] RawMax = {bptc_pkg::RawW{1'b1}};
  localparam longint          PresMax    = 64'sd2147483647;
  localparam longint          PresMin    = -64'sd2147483648;
  localparam int              CycleLimit = 200000;
  localparam int              BlockItems = 92;

  // word order: C6 down to C1
  localparam cal_set_t CalZero  = '0;
  localparam cal_set_t CalMax   = '1;
  localparam cal_set_t CalSheet = {16'd28312, 16'd33464, 16'd23282,
                                   16'd23317, 16'd36924, 16'd40127};
  // dT of -1 lands exactly one step below 20.00 C
  localparam cal_set_t CalEdge  = {16'd1, 16'd1, 16'd23282,
                                   16'd23317, 16'd36924, 16'd40127};
  // raw temperature 256 gives a first-order -15.00 C, 255 gives -15.01 C
  localparam cal_set_t CalCold  = {16'd32768, 16'd3501, 16'd23282,
                                   16'd23317, 16'd36924, 16'd40127};

  localparam reading_t AtReset = '{20'sd2000, 32'sd0};
  localparam reading_t NoWant  = '0;

  localparam stim_row_t DirRows [20] = '{
    '{1'b0, CalZero,  24'h000000, 24'h000000, 1'b1, AtReset},
    '{1'b0, CalZero,  RawMax,     RawMax,     1'b1, AtReset},
    '{1'b0, CalZero,  24'h555555, 24'hAAAAAA, 1'b1, AtReset},
    '{1'b0, CalZero,  24'hAAAAAA, 24'h555555, 1'b1, AtReset},
    '{1'b1, CalSheet, 24'd9085466, 24'd8569150, 1'b0, NoWant},
    '{1'b0, CalSheet, 24'h000000, 24'd8569150, 1'b0, NoWant},
    '{1'b0, CalSheet, RawMax,     24'd8569150, 1'b0, NoWant},
    '{1'b0, CalSheet, 24'd9085466, 24'h000000, 1'b0, NoWant},
    '{1'b0, CalSheet, 24'd9085466, RawMax,     1'b0, NoWant},
    '{1'b0, CalSheet, 24'd9085466, 24'd8000000, 1'b0, NoWant},
    '{1'b1, CalMax,   24'h000000, 24'h000000, 1'b0, NoWant},
    '{1'b0, CalMax,   RawMax,     RawMax,     1'b0, NoWant},
    '{1'b0, CalMax,   RawMax,     24'h000000, 1'b0, NoWant},
    '{1'b0, CalMax,   24'h000000, RawMax,     1'b0, NoWant},
    '{1'b1, CalEdge,  RawMax,     24'd256,    1'b0, NoWant},
    '{1'b0, CalEdge,  RawMax,     24'd255,    1'b0, NoWant},
    '{1'b1, CalCold,  24'h800000, 24'd256,    1'b0, NoWant},
    '{1'b0, CalCold,  24'h800000, 24'd255,    1'b0, NoWant},
    '{1'b1, CalZero,  24'h123456, 24'h654321, 1'b1, AtReset},
    '{1'b0, CalZero,  RawMax,     24'h000000, 1'b1, AtReset}
  };

  logic                                 clk;
  logic                                 rst;
  logic                                 start;
  logic                                 busy;
  logic [bptc_pkg::RawW-1:0]            raw_pressure;
  logic [bptc_pkg::RawW-1:0]            raw_temperature;
  logic                                 cfg_we;
  logic [bptc_pkg::CfgIdxW-1:0]         cfg_index;
  logic [bptc_pkg::CfgDataW-1:0]        cfg_data;
  logic                                 done;
  logic signed [bptc_pkg::TempW-1:0]    temperature_centi;
  logic signed [bptc_pkg::PresW-1:0]    pressure_centi_mbar;

  cal_set_t   cal_words;
  reading_t   expected_readings [$];
  int         mismatches;
  int         cycles;

  baro_pressure_temp_compensation_top dut (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .raw_pressure        (raw_pressure),
    .raw_temperature     (raw_temperature),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .done                (done),
    .temperature_centi   (temperature_centi),
    .pressure_centi_mbar (pressure_centi_mbar)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic reading_t compensate(input logic [bptc_pkg::RawW-1:0] d1_raw,
                                          input logic [bptc_pkg::RawW-1:0] d2_raw);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, t, off, sens, t2, off2, sens2, x, y, p;
    reading_t r;
    d1 = d1_raw;
    d2 = d2_raw;
    c1 = cal_words[bptc_pkg::RegPresSens];
    c2 = cal_words[bptc_pkg::RegPresOffset];
    c3 = cal_words[bptc_pkg::RegSensTc];
    c4 = cal_words[bptc_pkg::RegOffsetTc];
    c5 = cal_words[bptc_pkg::RegRefTemp];
    c6 = cal_words[bptc_pkg::RegTempCoeff];
    t2 = 0;
    off2 = 0;
    sens2 = 0;
    dt = d2 - c5 * 256;
    t = 2000 + ((dt * c6) >>> 23);
    off = c2 * 65536 + ((c4 * dt) >>> 7);
    sens = c1 * 32768 + ((c3 * dt) >>> 8);
    // second-order terms hinge on the first-order temperature
    if (t < 2000) begin
      x = t - 2000;
      t2 = (dt * dt) >>> 31;
      off2 = (5 * x * x) >>> 1;
      sens2 = (5 * x * x) >>> 2;
      if (t < -1500) begin
        y = t + 1500;
        off2 = off2 + 7 * y * y;
        sens2 = sens2 + ((11 * y * y) >>> 1);
      end
    end
    t = t - t2;
    off = off - off2;
    sens = sens - sens2;
    p = (((d1 * sens) >>> 21) - off) >>> 15;
    if (p > PresMax) p = PresMax;
    if (p < PresMin) p = PresMin;
    r.centi_deg = t[bptc_pkg::TempW-1:0];
    r.centi_mbar = p[bptc_pkg::PresW-1:0];
    return r;
  endfunction

  task automatic report(input string msg);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  task automatic cfg_write(input logic [bptc_pkg::CfgIdxW-1:0] idx,
                           input logic [bptc_pkg::CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx <= bptc_pkg::RegTempCoeff) cal_words[idx] = data;
    @(posedge clk);
  endtask

  // drain the pipe, then load a full calibration set plus a stray write
  task automatic load_cal(input cal_set_t cs);
    start <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    cfg_write(bptc_pkg::CfgIdxW'($urandom_range(RegSpareHi, RegSpareLo)),
              bptc_pkg::CfgDataW'($urandom));
    for (int i = 0; i <= bptc_pkg::RegTempCoeff; i++)
      cfg_write(bptc_pkg::CfgIdxW'(i), cs[i]);
    cfg_we <= 1'b0;
  endtask

  task automatic send_pair(input logic [bptc_pkg::RawW-1:0] d1,
                           input logic [bptc_pkg::RawW-1:0] d2,
                           input int idle_pct, input bit typed, input reading_t want);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    raw_pressure <= d1;
    raw_temperature <= d2;
    do @(posedge clk); while (busy);
    expected_readings.push_back(typed ? want : compensate(d1, d2));
  endtask

  function automatic logic [bptc_pkg::CfgDataW-1:0] rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return bptc_pkg::CfgDataW'($urandom);
    endcase
  endfunction

  function automatic logic [bptc_pkg::RawW-1:0] rand_pres_raw();
    case ($urandom_range(15))
      0: return '0;
      1: return RawMax;
      default: return bptc_pkg::RawW'($urandom);
    endcase
  endfunction

  // a quarter of the beats sit close to the reference temperature
  function automatic logic [bptc_pkg::RawW-1:0] rand_temp_raw();
    int v;
    if ($urandom_range(3) != 0) return bptc_pkg::RawW'($urandom);
    v = int'(cal_words[bptc_pkg::RegRefTemp]) * 256 + int'($urandom_range(8191)) - 4096;
    if (v < 0) v = 0;
    if (v > int'(RawMax)) v = int'(RawMax);
    return bptc_pkg::RawW'(v);
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (!rst && done) begin
      if (expected_readings.size() == 0) begin
        report("result with nothing pending");
      end else begin
        want = expected_readings.pop_front();
        if (temperature_centi !== want.centi_deg)
          report($sformatf("temperature_centi %0d, want %0d",
                           temperature_centi, want.centi_deg));
        if (pressure_centi_mbar !== want.centi_mbar)
          report($sformatf("pressure_centi_mbar %0d, want %0d",
                           pressure_centi_mbar, want.centi_mbar));
      end
    end
  end

  initial begin
    int idle_pct;
    cal_set_t cs;
    mismatches = 0;
    cycles = 0;
    cal_words = '0;
    rst <= 1'b1;
    start <= 1'b0;
    raw_pressure <= '0;
    raw_temperature <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < $size(DirRows); r++) begin
      if (DirRows[r].reload) load_cal(DirRows[r].cal);
      send_pair(DirRows[r].pres_raw, DirRows[r].temp_raw, 0,
                DirRows[r].typed, DirRows[r].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 13 : (ph == 1) ? 60 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        for (int i = 0; i <= bptc_pkg::RegTempCoeff; i++) cs[i] = rand_word();
        load_cal(cs);
        repeat (BlockItems) send_pair(rand_pres_raw(), rand_temp_raw(), idle_pct, 1'b0, NoWant);
      end
    end

    start <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    // room for any stray beat still in the pipe
    repeat (bptc_pkg::Latency + 4) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
